// ===== src/amfc_pkg.sv =====
// Shared types and constants for the ack/message frame checker.
package amfc_pkg;

  // Width of the per-frame byte position counter (saturates at its max).
  localparam int POS_BITS = 16;
  // Width used for mixed-width compares of positions and lengths.
  localparam int CMP_BITS = 33;

  localparam int BYTE_BITS = 8;
  localparam int LEN_BITS  = 16;
  localparam int ID_BITS   = 64;
  localparam int ID_BYTES  = ID_BITS / BYTE_BITS;

  // Frame layout
  localparam int ID_END        = 8;
  localparam int CHECKSUM_POS  = 9;
  localparam int PAYLOAD_START = 10;

  localparam logic [BYTE_BITS-1:0] KIND_ACK_BYTE = 8'h41;
  localparam logic [BYTE_BITS-1:0] KIND_MSG_BYTE = 8'h4D;

  localparam logic [LEN_BITS-1:0] CHECKED_LENGTH_RESET = 16'd150;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_MSG     = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_ACK       = 2'd0,
    VERDICT_GOOD      = 2'd1,
    VERDICT_MISMATCH  = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_t;

  // One result beat.
  typedef struct packed {
    logic [BYTE_BITS-1:0] payload_byte;
    logic                 payload_valid;
    logic                 frame_done;
    verdict_t             verdict;
    logic [ID_BITS-1:0]   message_id;
    logic [LEN_BITS-1:0]  payload_length;
  } result_t;

endpackage

// ===== src/amfc_parse.sv =====
// Per-byte frame parser: position tracking, id capture, checksum and verdict.
module amfc_parse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [amfc_pkg::BYTE_BITS-1:0]      rx_byte,
  input  logic                                frame_end,
  input  logic [amfc_pkg::LEN_BITS-1:0]       checked_length,
  output amfc_pkg::result_t                   result
);

  amfc_pkg::pos_t                       pos_r, pos_nxt;
  amfc_pkg::kind_t                      kind_r, kind_nxt, kind_upd;
  logic [amfc_pkg::ID_BITS-1:0]         id_r, id_nxt, id_upd;
  logic [amfc_pkg::BYTE_BITS-1:0]       sent_r, sent_nxt, sent_upd;
  logic [amfc_pkg::BYTE_BITS-1:0]       xor_r, xor_nxt, xor_upd;
  amfc_pkg::pos_t                       idx;
  logic [amfc_pkg::CMP_BITS-1:0]        idx_w;
  logic [amfc_pkg::CMP_BITS-1:0]        plen_w;
  logic                                 in_payload;

  // Update the frame fields for the byte at the current position
  always_comb begin
    kind_upd   = kind_r;
    id_upd     = id_r;
    sent_upd   = sent_r;
    xor_upd    = xor_r;
    in_payload = 1'b0;
    idx        = pos_r - amfc_pkg::pos_t'(amfc_pkg::PAYLOAD_START);
    idx_w      = amfc_pkg::CMP_BITS'(idx);
    if (pos_r == '0) begin
      id_upd   = '0;
      sent_upd = '0;
      xor_upd  = '0;
      if (rx_byte == amfc_pkg::KIND_ACK_BYTE) begin
        kind_upd = amfc_pkg::KIND_ACK;
      end else if (rx_byte == amfc_pkg::KIND_MSG_BYTE) begin
        kind_upd = amfc_pkg::KIND_MSG;
      end else begin
        kind_upd = amfc_pkg::KIND_BAD;
      end
    end else if (pos_r <= amfc_pkg::pos_t'(amfc_pkg::ID_END)) begin
      // Drop the byte into its little-endian id lane
      for (int i = 0; i < amfc_pkg::ID_BYTES; i++) begin
        if (pos_r == amfc_pkg::pos_t'(i + 1)) begin
          id_upd[i*amfc_pkg::BYTE_BITS +: amfc_pkg::BYTE_BITS] = rx_byte;
        end
      end
    end else if (pos_r == amfc_pkg::pos_t'(amfc_pkg::CHECKSUM_POS)) begin
      sent_upd = rx_byte;
    end else begin
      in_payload = (kind_r == amfc_pkg::KIND_MSG);
      if (idx_w >= amfc_pkg::CMP_BITS'(1) &&
          idx_w < amfc_pkg::CMP_BITS'(checked_length)) begin
        xor_upd = xor_r ^ rx_byte;
      end
    end
  end

  // Advance position, clear everything at the frame end
  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    id_nxt   = id_r;
    sent_nxt = sent_r;
    xor_nxt  = xor_r;
    if (accept) begin
      if (frame_end) begin
        pos_nxt  = '0;
        kind_nxt = amfc_pkg::KIND_UNKNOWN;
        id_nxt   = '0;
        sent_nxt = '0;
        xor_nxt  = '0;
      end else begin
        pos_nxt  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
        kind_nxt = kind_upd;
        id_nxt   = id_upd;
        sent_nxt = sent_upd;
        xor_nxt  = xor_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= amfc_pkg::KIND_UNKNOWN;
      id_r   <= '0;
      sent_r <= '0;
      xor_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      id_r   <= id_nxt;
      sent_r <= sent_nxt;
      xor_r  <= xor_nxt;
    end
  end

  // Payload count of a finished message: bytes from position 10 on
  assign plen_w = amfc_pkg::CMP_BITS'(pos_r) - amfc_pkg::CMP_BITS'(amfc_pkg::CHECKSUM_POS);

  // Build the result beat for this byte
  always_comb begin
    result                = '0;
    result.payload_valid  = in_payload;
    result.payload_byte   = in_payload ? rx_byte : '0;
    result.frame_done     = frame_end;
    result.verdict        = amfc_pkg::VERDICT_ACK;
    if (frame_end) begin
      result.message_id = id_upd;
      if (kind_upd == amfc_pkg::KIND_ACK &&
          pos_r >= amfc_pkg::pos_t'(amfc_pkg::ID_END)) begin
        result.verdict = amfc_pkg::VERDICT_ACK;
      end else if (kind_upd == amfc_pkg::KIND_MSG &&
                   pos_r >= amfc_pkg::pos_t'(amfc_pkg::CHECKSUM_POS)) begin
        result.verdict = (xor_upd == sent_upd) ? amfc_pkg::VERDICT_GOOD
                                               : amfc_pkg::VERDICT_MISMATCH;
        result.payload_length =
          (plen_w > amfc_pkg::CMP_BITS'(amfc_pkg::LEN_MAX)) ? amfc_pkg::LEN_MAX
                                                             : plen_w[amfc_pkg::LEN_BITS-1:0];
      end else begin
        result.verdict = amfc_pkg::VERDICT_MALFORMED;
      end
    end
  end

endmodule

// ===== src/ack_message_frame_checker.sv =====
// Top level of the ack/message frame checker: stream ports, config and output register.
//
// Takes one frame byte per beat ('A' ack or 'M' message kind byte, 8-byte
// little-endian id, then for messages a checksum byte and payload) and gives
// exactly one result beat per input beat. Payload bytes of a message are
// flagged on out_tuser; the beat that carries in_tlast reports the verdict,
// id and payload length. The block takes one byte every cycle while the sink
// keeps up; the parse logic sits between the input handshake and one output
// register, so each result shows in the cycle after its byte is accepted. in_tready
// stays high unless that register holds a beat that the sink has not taken. The
// user must write checked_length through cfg_wr_en between frames (unenforced).
module ack_message_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  input  logic                                in_tlast,   // frame_end
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] payload_byte, [9:8] verdict, [73:10] message_id,
  // [89:74] payload_length, [95:90] zero
  output logic [95:0]                         out_tdata,
  output logic                                out_tlast,  // frame_done
  output logic                                out_tuser,  // payload_valid
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic [amfc_pkg::LEN_BITS-1:0]       cfg_wr_data // checked_length
);

  logic [amfc_pkg::LEN_BITS-1:0] checked_length_r;
  logic                          accept;
  amfc_pkg::result_t             result;
  amfc_pkg::result_t             out_r;
  logic                          out_valid_r, out_valid_nxt;

  // Hold the checked length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checked_length_r <= amfc_pkg::CHECKED_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      checked_length_r <= cfg_wr_data;
    end
  end

  // Take a beat whenever the output register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  amfc_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .rx_byte        (in_tdata),
    .frame_end      (in_tlast),
    .checked_length (checked_length_r),
    .result         (result)
  );

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.frame_done;
  assign out_tuser  = out_r.payload_valid;
  assign out_tdata  = {6'd0, out_r.payload_length, out_r.message_id,
                       out_r.verdict, out_r.payload_byte};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ack/message frame checker stream block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_BYTES = 125;
  localparam int MAX_FRAME_BYTES = 256;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [amfc_pkg::LEN_BITS-1:0] cfg_wr_data;

  // One directed row: input byte, end marker, and a typed verdict where pinned
  typedef struct packed {
    logic [7:0]                   rx;
    logic                         last;
    logic                         pinned;
    amfc_pkg::verdict_t           verdict;
    logic [amfc_pkg::ID_BITS-1:0] id;
  } dir_row_t;

  // Frame parser mirror: state and checked length
  amfc_pkg::pos_t                cur_pos;
  amfc_pkg::kind_t               cur_kind;
  logic [amfc_pkg::ID_BITS-1:0]  cur_id;
  logic [7:0]                    cur_sent_sum;
  logic [7:0]                    cur_xor;
  logic [amfc_pkg::LEN_BITS-1:0] checked_len;

  amfc_pkg::result_t pending_beats[$];
  int unsigned       mismatch_count;
  int unsigned       bytes_sent;
  int unsigned       cycle_count = 0;
  bit                sender_gaps;
  bit                sink_stalls;

  ack_message_frame_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Advance the parser mirror by one byte and return the result beat it causes
  function automatic amfc_pkg::result_t parse_frame_byte(logic [7:0] b, logic last);
    amfc_pkg::result_t r;
    int unsigned       idx;
    int unsigned       cnt;
    int unsigned       plen;
    r = '0;
    if (cur_pos == 0) begin
      cur_id = '0;
      cur_sent_sum = '0;
      cur_xor = '0;
      if (b == amfc_pkg::KIND_ACK_BYTE) cur_kind = amfc_pkg::KIND_ACK;
      else if (b == amfc_pkg::KIND_MSG_BYTE) cur_kind = amfc_pkg::KIND_MSG;
      else cur_kind = amfc_pkg::KIND_BAD;
    end else if (cur_pos <= amfc_pkg::ID_END) begin
      cur_id[8*(int'(cur_pos)-1) +: 8] = b;
    end else if (cur_pos == amfc_pkg::CHECKSUM_POS) begin
      cur_sent_sum = b;
    end else begin
      idx = int'(cur_pos) - amfc_pkg::PAYLOAD_START;
      if (cur_kind == amfc_pkg::KIND_MSG) begin
        r.payload_byte = b;
        r.payload_valid = 1'b1;
      end
      if (idx >= 1 && idx < checked_len) cur_xor ^= b;
    end
    cnt = int'(cur_pos) + 1;
    // hold the position at its maximum on over-long frames
    if (cur_pos != '1) cur_pos = cur_pos + 1'b1;
    if (last) begin
      r.frame_done = 1'b1;
      r.message_id = cur_id;
      if (cur_kind == amfc_pkg::KIND_ACK && cnt >= amfc_pkg::ID_END + 1) begin
        r.verdict = amfc_pkg::VERDICT_ACK;
      end else if (cur_kind == amfc_pkg::KIND_MSG && cnt >= amfc_pkg::PAYLOAD_START) begin
        r.verdict = (cur_xor == cur_sent_sum) ? amfc_pkg::VERDICT_GOOD
                                              : amfc_pkg::VERDICT_MISMATCH;
        plen = cnt - amfc_pkg::PAYLOAD_START;
        r.payload_length = (plen > amfc_pkg::LEN_MAX) ? amfc_pkg::LEN_MAX
                                                      : plen[amfc_pkg::LEN_BITS-1:0];
      end else begin
        r.verdict = amfc_pkg::VERDICT_MALFORMED;
      end
      cur_pos = '0;
      cur_kind = amfc_pkg::KIND_UNKNOWN;
      cur_id = '0;
      cur_sent_sum = '0;
      cur_xor = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h at cycle %0d", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Send one byte after a random gap; queue its expected beat on acceptance
  task automatic push_byte(input logic [7:0] rx, input logic last, input logic pinned,
                           input amfc_pkg::result_t pin_want);
    int unsigned       gap;
    amfc_pkg::result_t want;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rx;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    want = parse_frame_byte(rx, last);
    if (pinned) want = pin_want;
    pending_beats.insert(pending_beats.size(), want);
    bytes_sent++;
  endtask

  // Stop sending and wait for every expected beat
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_checked_length(input logic [amfc_pkg::LEN_BITS-1:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    checked_len = value;
  endtask

  // Build and send one frame; optionally make the checksum byte match the payload
  task automatic send_frame(input logic [7:0] kind_byte, input int total, input bit good_sum);
    logic [7:0] body [MAX_FRAME_BYTES];
    logic [7:0] sum;
    int         plen;
    int         span;
    int         i;
    body[0] = kind_byte;
    for (i = 1; i < total; i++) body[i] = 8'($urandom_range(0, 255));
    if (kind_byte == amfc_pkg::KIND_MSG_BYTE && total >= amfc_pkg::PAYLOAD_START &&
        good_sum) begin
      plen = total - amfc_pkg::PAYLOAD_START;
      span = (int'(checked_len) < plen) ? int'(checked_len) : plen;
      sum = '0;
      for (i = 1; i < span; i++) sum ^= body[amfc_pkg::PAYLOAD_START + i];
      body[amfc_pkg::CHECKSUM_POS] = sum;
    end
    for (i = 0; i < total; i++) push_byte(body[i], i == total - 1, 1'b0, '0);
  endtask

  // Result sink: stall at random, then check each accepted beat
  initial begin
    int unsigned       stall;
    amfc_pkg::result_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[63:0], 64'h0);
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (out_tdata[7:0] !== want.payload_byte)
          report_mismatch("payload_byte", 64'(out_tdata[7:0]), 64'(want.payload_byte));
        if (out_tuser !== want.payload_valid)
          report_mismatch("payload_valid", 64'(out_tuser), 64'(want.payload_valid));
        if (out_tlast !== want.frame_done)
          report_mismatch("frame_done", 64'(out_tlast), 64'(want.frame_done));
        if (out_tdata[9:8] !== want.verdict)
          report_mismatch("verdict", 64'(out_tdata[9:8]), 64'(want.verdict));
        if (out_tdata[73:10] !== want.message_id)
          report_mismatch("message_id", out_tdata[73:10], want.message_id);
        if (out_tdata[89:74] !== want.payload_length)
          report_mismatch("payload_length", 64'(out_tdata[89:74]),
                          64'(want.payload_length));
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t                      dir_rows [24];
    logic [amfc_pkg::LEN_BITS-1:0] len_plan [7];
    amfc_pkg::result_t             pin_want;
    int unsigned                   pick;
    int                            total;
    int                            p;
    int                            r;
    int unsigned                   phase_end;
    logic [7:0]                    kind_byte;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatch_count = 0;
    bytes_sent = 0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    cur_pos = '0;
    cur_kind = amfc_pkg::KIND_UNKNOWN;
    cur_id = '0;
    cur_sent_sum = '0;
    cur_xor = '0;
    checked_len = amfc_pkg::CHECKED_LENGTH_RESET;

    // bad kind, ack with extra byte, empty-payload message with wrong checksum,
    // short ack, short message
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, amfc_pkg::VERDICT_MALFORMED, 64'h0},
      '{8'h41, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h00, 1'b1, 1'b1, amfc_pkg::VERDICT_ACK, 64'hFFFF_FFFF_FFFF_FFFF},
      '{8'h4D, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h01, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h02, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h03, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h04, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h05, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h06, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h07, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h08, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'hFF, 1'b1, 1'b1, amfc_pkg::VERDICT_MISMATCH, 64'h0807_0605_0403_0201},
      '{8'h41, 1'b0, 1'b0, amfc_pkg::VERDICT_ACK, 64'h0},
      '{8'h12, 1'b1, 1'b1, amfc_pkg::VERDICT_MALFORMED, 64'h12},
      '{8'h4D, 1'b1, 1'b1, amfc_pkg::VERDICT_MALFORMED, 64'h0}
    };
    len_plan = '{16'd0, 16'd1, 16'd2, 16'd9, 16'd150, 16'hFFFF, 16'h0};
    len_plan[6] = amfc_pkg::LEN_BITS'($urandom_range(0, 65535));

    // hold reset, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset checked length
    for (r = 0; r < 24; r++) begin
      pin_want = '0;
      pin_want.frame_done = 1'b1;
      pin_want.verdict = dir_rows[r].verdict;
      pin_want.message_id = dir_rows[r].id;
      push_byte(dir_rows[r].rx, dir_rows[r].last, dir_rows[r].pinned, pin_want);
    end

    // random frames, one checked length per phase, mixing gap and stall settings
    for (p = 0; p < 7; p++) begin
      write_checked_length(len_plan[p]);
      sender_gaps = (p % 3) != 1;
      sink_stalls = (p % 3) != 2;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          kind_byte = amfc_pkg::KIND_MSG_BYTE;
          if ($urandom_range(0, 9) == 0) total = $urandom_range(1, 9);
          else if ($urandom_range(0, 19) == 0)
            total = amfc_pkg::PAYLOAD_START + $urandom_range(0, 180);
          else total = amfc_pkg::PAYLOAD_START + $urandom_range(0, 16);
        end else if (pick < 92) begin
          kind_byte = amfc_pkg::KIND_ACK_BYTE;
          total = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 12);
        end else begin
          kind_byte = 8'($urandom_range(0, 255));
          total = $urandom_range(1, 12);
        end
        send_frame(kind_byte, total, 1'($urandom_range(0, 1)));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
